### hw/rtl/msgpkt_pkg.sv
// Package for the message packetiser: sizes, register indices and the packet record.
`timescale 1ns / 1ps

package msgpkt_pkg;

  localparam int WORDS_PER_PACKET = 6;
  localparam int SLOT_COUNT       = 6;
  localparam int FILL_W           = $clog2(WORDS_PER_PACKET + 1);
  localparam int WORDS_W          = 14;
  localparam int INDEX_W          = 12;
  localparam int OUT_DEPTH        = 4;
  localparam int PTR_W            = $clog2(OUT_DEPTH);
  localparam int CNT_W            = $clog2(OUT_DEPTH + 1);

  // Configuration register indices.
  localparam logic REG_NODE_ID   = 1'b0;
  localparam logic REG_BUS_TABLE = 1'b1;

  typedef struct packed {
    logic [7:0]         node_field;
    logic [7:0]         sender_id;
    logic [7:0]         receiver_id;
    logic [INDEX_W-1:0] packet_index;
    logic [3:0]         bus_id;
    logic [4:0]         valid_bytes;
    logic [63:0]        words_first_pair;
    logic [63:0]        words_second_pair;
    logic [63:0]        words_third_pair;
    logic               last_packet;
  } pkt_t;

endpackage

### hw/rtl/message_packetizer.sv
// Top level of the message packetiser: header decode, packet assembly and result queue.
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ------------------------------------------
//  input    in         in_valid / in_stall   word (32)
//  output   out        out_valid / out_stall node_field, sender_id, receiver_id,
//                                            packet_index, bus_id, valid_bytes,
//                                            words_*_pair (3 x 64), last_packet
//  config   in         cfg_valid / cfg_ready cfg_index (1), cfg_data (64)
//
// Each word is captured in the input register; from there the header decode or the
// packet fill runs and any finished packets are written into a four-entry result
// queue. A word is accepted in every cycle while the queue has room for two packets,
// so the sustained rate is one word per cycle. Reset is synchronous and leaves the
// block waiting for a header with an empty queue. A stall on the output only holds the
// input side once the queue cannot take the worst case of two packets from one word.
`timescale 1ns / 1ps

module message_packetizer
  import msgpkt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         word,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          node_field,
  output logic [7:0]          sender_id,
  output logic [7:0]          receiver_id,
  output logic [INDEX_W-1:0]  packet_index,
  output logic [3:0]          bus_id,
  output logic [4:0]          valid_bytes,
  output logic [63:0]         words_first_pair,
  output logic [63:0]         words_second_pair,
  output logic [63:0]         words_third_pair,
  output logic                last_packet,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);

  // Configuration registers. The user must make writes arrive only while the block is
  // idle; the block itself does not enforce this. Writes are always accepted.
  logic [7:0]  node_id;
  logic [63:0] bus_id_table;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id      <= '0;
      bus_id_table <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_ID:   node_id      <= cfg_data[7:0];
        REG_BUS_TABLE: bus_id_table <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic        in_reg_valid;
  logic [31:0] in_reg_word;
  logic        advance;

  // Result queue.
  pkt_t             queue [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // The stage moves only when the queue can take two packets.
  assign advance  = in_reg_valid && (count <= CNT_W'(OUT_DEPTH - 2));
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_word <= word;
    end
  end

  // Message state.
  logic               awaiting_header;
  logic [7:0]         receiver_reg;
  logic [7:0]         sender_reg;
  logic [WORDS_W-1:0] words_remaining;
  logic [INDEX_W-1:0] index_counter;
  logic [FILL_W-1:0]  fill_count;
  logic               size_has_tail;
  logic [31:0]        packet_words [WORDS_PER_PACKET-1];

  logic               awaiting_header_next;
  logic [WORDS_W-1:0] words_remaining_next;
  logic [INDEX_W-1:0] index_counter_next;
  logic [FILL_W-1:0]  fill_count_next;
  logic               store_word;

  logic [15:0]        hdr_size;
  logic [FILL_W-1:0]  fill_inc;
  logic               final_word;
  logic               packet_full;
  logic [3:0]         lookup_bus;
  logic [31:0]        slot_word [SLOT_COUNT];
  logic [1:0]         push_count;
  pkt_t               data_pkt;
  pkt_t               empty_pkt;
  pkt_t               first_pkt;

  assign hdr_size    = in_reg_word[15:0];
  assign fill_inc    = fill_count + FILL_W'(1);
  assign final_word  = (words_remaining == WORDS_W'(1));
  assign packet_full = (fill_inc == FILL_W'(WORDS_PER_PACKET));

  // Receiver ids beyond the table give bus zero.
  always_comb begin
    if (receiver_reg > 8'd15) begin
      lookup_bus = '0;
    end else begin
      lookup_bus = bus_id_table[{receiver_reg[3:0], 2'b00} +: 4];
    end
  end

  // Stored words below the fill point, the current word at it, zeros above.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if ((i < WORDS_PER_PACKET - 1) && (FILL_W'(i) < fill_count)) begin
        slot_word[i] = packet_words[i];
      end else if (FILL_W'(i) == fill_count) begin
        slot_word[i] = in_reg_word;
      end else begin
        slot_word[i] = '0;
      end
    end
  end

  always_comb begin
    data_pkt.node_field        = node_id;
    data_pkt.sender_id         = sender_reg;
    data_pkt.receiver_id       = receiver_reg;
    data_pkt.packet_index      = index_counter;
    data_pkt.bus_id            = lookup_bus;
    data_pkt.valid_bytes       = 5'({fill_inc, 2'b00});
    data_pkt.words_first_pair  = {slot_word[0], slot_word[1]};
    data_pkt.words_second_pair = {slot_word[2], slot_word[3]};
    data_pkt.words_third_pair  = {slot_word[4], slot_word[5]};
    // A size tail that falls after a full packet needs a packet of its own.
    data_pkt.last_packet       = final_word && !(size_has_tail && packet_full);

    // The remainder packet follows the data packet, so it takes the next index.
    empty_pkt                  = data_pkt;
    empty_pkt.packet_index     = index_counter + INDEX_W'(1);
    empty_pkt.valid_bytes      = '0;
    empty_pkt.words_first_pair = '0;
    empty_pkt.words_second_pair = '0;
    empty_pkt.words_third_pair = '0;
    empty_pkt.last_packet      = 1'b1;
  end

  // Per-word decode: header or payload.
  always_comb begin
    awaiting_header_next = awaiting_header;
    words_remaining_next = words_remaining;
    index_counter_next   = index_counter;
    fill_count_next      = fill_count;
    store_word           = 1'b0;
    push_count           = 2'd0;
    first_pkt            = data_pkt;

    if (awaiting_header) begin
      words_remaining_next = hdr_size[15:2];
      index_counter_next   = '0;
      fill_count_next      = '0;
      if (hdr_size != 16'd0) begin
        awaiting_header_next = 1'b0;
        if (hdr_size[15:2] == WORDS_W'(0)) begin
          // Size below four bytes: a single empty packet, index zero, ids from this
          // header.
          first_pkt                 = empty_pkt;
          first_pkt.sender_id       = in_reg_word[23:16];
          first_pkt.receiver_id     = in_reg_word[31:24];
          first_pkt.packet_index    = '0;
          first_pkt.bus_id          = (in_reg_word[31:24] > 8'd15) ? 4'd0 :
                                      bus_id_table[{in_reg_word[27:24], 2'b00} +: 4];
          push_count                = 2'd1;
          awaiting_header_next      = 1'b1;
          index_counter_next        = INDEX_W'(1);
        end
      end
    end else begin
      words_remaining_next = words_remaining - WORDS_W'(1);
      if (packet_full || final_word) begin
        push_count         = 2'd1;
        fill_count_next    = '0;
        index_counter_next = index_counter + INDEX_W'(1);
        if (final_word && size_has_tail && packet_full) begin
          push_count         = 2'd2;
          index_counter_next = index_counter + INDEX_W'(2);
        end
      end else begin
        fill_count_next = fill_inc;
        store_word      = 1'b1;
      end
      if (final_word) begin
        awaiting_header_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_header <= 1'b1;
      receiver_reg    <= '0;
      sender_reg      <= '0;
      words_remaining <= '0;
      index_counter   <= '0;
      fill_count      <= '0;
      size_has_tail   <= 1'b0;
    end else if (advance) begin
      awaiting_header <= awaiting_header_next;
      words_remaining <= words_remaining_next;
      index_counter   <= index_counter_next;
      fill_count      <= fill_count_next;
      if (awaiting_header) begin
        receiver_reg  <= in_reg_word[31:24];
        sender_reg    <= in_reg_word[23:16];
        size_has_tail <= |hdr_size[1:0];
      end
    end
  end

  // Payload slots; slots above the fill point are masked on output, so they need no
  // clearing.
  always_ff @(posedge clk) begin
    if (advance && store_word) begin
      packet_words[fill_count] <= in_reg_word;
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  logic pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (advance && (push_count != 2'd0)) begin
      queue[wr_ptr] <= first_pkt;
    end
    if (advance && (push_count == 2'd2)) begin
      queue[wr_ptr + PTR_W'(1)] <= empty_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + PTR_W'(push_count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (advance ? CNT_W'(push_count) : CNT_W'(0)) - CNT_W'(pop);
    end
  end

  assign node_field        = queue[rd_ptr].node_field;
  assign sender_id         = queue[rd_ptr].sender_id;
  assign receiver_id       = queue[rd_ptr].receiver_id;
  assign packet_index      = queue[rd_ptr].packet_index;
  assign bus_id            = queue[rd_ptr].bus_id;
  assign valid_bytes       = queue[rd_ptr].valid_bytes;
  assign words_first_pair  = queue[rd_ptr].words_first_pair;
  assign words_second_pair = queue[rd_ptr].words_second_pair;
  assign words_third_pair  = queue[rd_ptr].words_third_pair;
  assign last_packet       = queue[rd_ptr].last_packet;

endmodule

### tb/message_packetizer_test.sv
// Self-checking testbench for the message packetiser: streams messages and checks every packet.
`timescale 1ns / 1ps

module message_packetizer_test;
  import msgpkt_pkg::*;

  // Clock, reset and every input of the block start at a known value.
  logic               clk = 1'b0;
  logic               rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        word = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         node_field;
  logic [7:0]         sender_id;
  logic [7:0]         receiver_id;
  logic [INDEX_W-1:0] packet_index;
  logic [3:0]         bus_id;
  logic [4:0]         valid_bytes;
  logic [63:0]        words_first_pair;
  logic [63:0]        words_second_pair;
  logic [63:0]        words_third_pair;
  logic               last_packet;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_NODE_ID;
  logic [63:0]        cfg_data = '0;

  // Output stall patterns; the receiver stall redraws the pattern at random.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_t;

  localparam int BYTES_PER_PACKET = 4 * WORDS_PER_PACKET;
  localparam int LONG_HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES    = 8;
  localparam int MAX_REPORTS      = 50;

  message_packetizer u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .word             (word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .node_field       (node_field),
    .sender_id        (sender_id),
    .receiver_id      (receiver_id),
    .packet_index     (packet_index),
    .bus_id           (bus_id),
    .valid_bytes      (valid_bytes),
    .words_first_pair (words_first_pair),
    .words_second_pair(words_second_pair),
    .words_third_pair (words_third_pair),
    .last_packet      (last_packet),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Packet predictor. It mirrors the block's message state and its two
  // registers, and turns every accepted word into the packets it must cause.
  // ---------------------------------------------------------------------------
  logic [7:0]         node_setting      = '0;
  logic [63:0]        bus_table_setting = '0;

  logic               awaiting_header = 1'b1;
  logic [7:0]         receiver_held   = '0;
  logic [7:0]         sender_held     = '0;
  logic [13:0]        words_left      = '0;
  int                 packets_left    = 0;
  logic [INDEX_W-1:0] index_count     = '0;
  int                 fill_count      = 0;
  logic [31:0]        packet_slots [SLOT_COUNT];

  pkt_t               expected_packets [$];
  logic [31:0]        pending_words [$];

  int                 mismatch_count = 0;

  function automatic void clear_slots();
    fill_count = 0;
    for (int i = 0; i < SLOT_COUNT; i++) packet_slots[i] = '0;
  endfunction

  // Closes the packet being filled and files it as the next expected result.
  function automatic void emit_packet();
    pkt_t p;
    p.node_field        = node_setting;
    p.sender_id         = sender_held;
    p.receiver_id       = receiver_held;
    p.packet_index      = index_count;
    // Only receivers 0 to 15 have an entry in the bus table.
    p.bus_id            = (receiver_held > 8'd15) ? 4'd0 :
                          bus_table_setting[{receiver_held[3:0], 2'b00} +: 4];
    p.valid_bytes       = 5'(fill_count * 4);
    p.words_first_pair  = {packet_slots[0], packet_slots[1]};
    p.words_second_pair = {packet_slots[2], packet_slots[3]};
    p.words_third_pair  = {packet_slots[4], packet_slots[5]};
    p.last_packet       = (packets_left <= 1);
    expected_packets.push_back(p);
    if (packets_left > 0) packets_left--;
    index_count++;
    clear_slots();
    if (packets_left == 0) awaiting_header = 1'b1;
  endfunction

  function automatic void packetize_word(input logic [31:0] w);
    int size_bytes;
    if (awaiting_header) begin
      size_bytes    = w[15:0];
      receiver_held = w[31:24];
      sender_held   = w[23:16];
      words_left    = w[15:2];
      packets_left  = (size_bytes + BYTES_PER_PACKET - 1) / BYTES_PER_PACKET;
      index_count   = '0;
      clear_slots();
      // A zero size gives nothing and leaves the block waiting for a header.
      if (packets_left == 0) return;
      awaiting_header = 1'b0;
      // Fewer than four bytes: the header alone yields one empty last packet.
      if (words_left == 0) emit_packet();
      return;
    end
    if (fill_count < SLOT_COUNT) packet_slots[fill_count] = w;
    fill_count++;
    if (words_left > 0) words_left--;
    if (fill_count >= WORDS_PER_PACKET || words_left == 0) emit_packet();
    // A size remainder may still owe an empty packet after the last data packet.
    if (words_left == 0 && packets_left > 0) emit_packet();
    if (words_left == 0) awaiting_header = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_packet(input pkt_t got, input pkt_t want);
    if (got.node_field !== want.node_field)
      report_mismatch($sformatf("packet %0d node_field %h, predicted %h",
                                want.packet_index, got.node_field, want.node_field));
    if (got.sender_id !== want.sender_id)
      report_mismatch($sformatf("packet %0d sender_id %h, predicted %h",
                                want.packet_index, got.sender_id, want.sender_id));
    if (got.receiver_id !== want.receiver_id)
      report_mismatch($sformatf("packet %0d receiver_id %h, predicted %h",
                                want.packet_index, got.receiver_id, want.receiver_id));
    if (got.packet_index !== want.packet_index)
      report_mismatch($sformatf("packet_index %0d, predicted %0d",
                                got.packet_index, want.packet_index));
    if (got.bus_id !== want.bus_id)
      report_mismatch($sformatf("packet %0d bus_id %h, predicted %h",
                                want.packet_index, got.bus_id, want.bus_id));
    if (got.valid_bytes !== want.valid_bytes)
      report_mismatch($sformatf("packet %0d valid_bytes %0d, predicted %0d",
                                want.packet_index, got.valid_bytes, want.valid_bytes));
    if (got.words_first_pair !== want.words_first_pair)
      report_mismatch($sformatf("packet %0d words_first_pair %h, predicted %h",
                                want.packet_index, got.words_first_pair,
                                want.words_first_pair));
    if (got.words_second_pair !== want.words_second_pair)
      report_mismatch($sformatf("packet %0d words_second_pair %h, predicted %h",
                                want.packet_index, got.words_second_pair,
                                want.words_second_pair));
    if (got.words_third_pair !== want.words_third_pair)
      report_mismatch($sformatf("packet %0d words_third_pair %h, predicted %h",
                                want.packet_index, got.words_third_pair,
                                want.words_third_pair));
    if (got.last_packet !== want.last_packet)
      report_mismatch($sformatf("packet %0d last_packet %b, predicted %b",
                                want.packet_index, got.last_packet, want.last_packet));
  endtask

  // Monitor: every packet transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    pkt_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {node_field, sender_id, receiver_id, packet_index, bus_id, valid_bytes,
             words_first_pair, words_second_pair, words_third_pair, last_packet};
      if (expected_packets.size() == 0)
        report_mismatch($sformatf("packet from receiver %h index %0d with none predicted",
                                  receiver_id, packet_index));
      else
        check_packet(got, expected_packets.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // Word driver. It sends in bursts of random length separated by random gaps;
  // a quarter of the bursts are long and gap-free. A stalled word is held.
  // The predictor runs at the edge where a word transaction completes.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) packetize_word(word);

      if (in_valid && in_stall) begin
        // Hold the current word until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        word     <= pending_words.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 3) == 0) begin
          burst_left = 64;
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall. Its own pattern is redrawn at random. Once asked, it
  // holds off for a long stretch so that the result queue fills and the block
  // has to stall the word input.
  // ---------------------------------------------------------------------------
  stall_pattern_t stall_pattern = STALL_NONE;
  int             stall_cycle   = 0;
  int             hold_left     = 0;
  logic           hold_request  = 1'b0;
  logic           hold_started  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_cycle++;
      if (stall_cycle % 64 == 0) stall_pattern = stall_pattern_t'($urandom_range(0, 3));
      if (hold_request && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_pattern)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_HALF:     out_stall <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 4) != 0);
          STALL_PERIODIC: out_stall <= (stall_cycle % 5 < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_message(input logic [7:0] rx, input logic [7:0] tx,
                               input logic [15:0] size_bytes, output int word_total);
    pending_words.push_back({rx, tx, size_bytes});
    for (int i = 0; i < size_bytes / 4; i++) pending_words.push_back($urandom);
    word_total = 1 + size_bytes / 4;
  endtask

  // Mostly short messages with every kind of size remainder, some zero and
  // sub-word sizes, and now and then a longer one. Most receivers have a
  // table entry; the rest exercise the ids above the table.
  task automatic queue_random_message(output int word_total);
    int          pick;
    logic [7:0]  rx;
    logic [15:0] size_bytes;
    pick = $urandom_range(0, 99);
    if (pick < 5)       size_bytes = 16'd0;
    else if (pick < 15) size_bytes = 16'($urandom_range(1, 3));
    else if (pick < 70) size_bytes = 16'($urandom_range(4, 60));
    else if (pick < 92) size_bytes = 16'($urandom_range(61, 200));
    else                size_bytes = 16'($urandom_range(201, 600));
    rx = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(16, 255));
    queue_message(rx, 8'($urandom), size_bytes, word_total);
  endtask

  task automatic queue_random_words(input int target);
    int queued;
    int word_total;
    queued = 0;
    while (queued < target) begin
      queue_random_message(word_total);
      queued += word_total;
    end
  endtask

  // Waits until every word has gone in and every predicted packet has come
  // out, then lets the pipeline settle, since a zero-size header causes no
  // packet that could be waited for.
  task automatic wait_until_idle();
    while (pending_words.size() != 0 || in_valid || expected_packets.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; the node id rides on random upper bits,
  // which the block must ignore.
  task automatic configure(input logic [7:0] node, input logic [63:0] bus_table);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NODE_ID;
    cfg_data  <= {$urandom, 24'($urandom), node};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_BUS_TABLE;
    cfg_data  <= bus_table;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    node_setting      = node;
    bus_table_setting = bus_table;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int word_total;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed messages under the reset register values: zero sizes with the
    // extreme ids, a sub-word size, an exactly full packet carrying extreme
    // words, a full packet owing an empty remainder packet, and a message that
    // spills one word into a second packet.
    queue_message(8'hFF, 8'hFF, 16'd0, word_total);
    queue_message(8'h00, 8'h00, 16'd0, word_total);
    queue_message(8'h0F, 8'h81, 16'd3, word_total);
    pending_words.push_back({8'hFF, 8'h00, 16'd24});
    pending_words.push_back(32'hFFFF_FFFF);
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hAAAA_AAAA);
    pending_words.push_back(32'h5555_5555);
    pending_words.push_back(32'h8000_0001);
    pending_words.push_back(32'h7FFF_FFFE);
    queue_message(8'h10, 8'h7E, 16'd26, word_total);
    queue_message(8'h00, 8'hFF, 16'd28, word_total);
    wait_until_idle();

    // All ones in both registers.
    configure(8'hFF, {64{1'b1}});
    queue_random_words(90);
    wait_until_idle();

    // Random settings, with the long receiver hold-off during this phase.
    configure(8'($urandom), {$urandom, $urandom});
    queue_random_words(100);
    hold_request <= 1'b1;
    wait_until_idle();

    // Node id zero, then one long message whose last data packet is full and
    // which still owes an empty remainder packet.
    configure(8'h00, {$urandom, $urandom});
    queue_random_words(60);
    queue_message(8'($urandom_range(0, 15)), 8'($urandom), 16'd290, word_total);
    wait_until_idle();

    // An all-zero bus table.
    configure(8'($urandom), 64'h0);
    queue_random_words(40);
    wait_until_idle();

    if (expected_packets.size() != 0)
      report_mismatch($sformatf("%0d predicted packets never arrived",
                                expected_packets.size()));

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a run that has not finished by now has hung somewhere.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### message_packetizer.f
hw/rtl/msgpkt_pkg.sv
hw/rtl/message_packetizer.sv
tb/message_packetizer_test.sv
